// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands on the module clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge, muted while arst_n is low.
`define STS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define STS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, codes and decode functions for the trading state table.
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int LOCATE_COUNT = 65536;
	localparam int ADDR_W       = $clog2(LOCATE_COUNT);
	localparam int STATE_W      = 3;
	localparam logic [16:0] LOC_LIMIT = 17'(LOCATE_COUNT);

	// opcodes
	localparam logic [1:0] OP_REGISTER = 2'd0;
	localparam logic [1:0] OP_SYSTEM   = 2'd1;
	localparam logic [1:0] OP_TRADE    = 2'd2;
	localparam logic [1:0] OP_QUERY    = 2'd3;

	// status codes
	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_LOC_ZERO  = 3'd1;
	localparam logic [2:0] STAT_NONGLOBAL = 3'd2;
	localparam logic [2:0] STAT_BAD_EVENT = 3'd3;
	localparam logic [2:0] STAT_ORDER     = 3'd4;
	localparam logic [2:0] STAT_UNREG     = 3'd5;
	localparam logic [2:0] STAT_CLOSED    = 3'd6;
	localparam logic [2:0] STAT_BAD_STATE = 3'd7;

	// instrument states
	localparam logic [STATE_W-1:0] ST_NONE    = 3'd0;
	localparam logic [STATE_W-1:0] ST_PREOPEN = 3'd1;
	localparam logic [STATE_W-1:0] ST_TRADING = 3'd2;
	localparam logic [STATE_W-1:0] ST_HALTED  = 3'd3;
	localparam logic [STATE_W-1:0] ST_PAUSED  = 3'd4;
	localparam logic [STATE_W-1:0] ST_QUOTE   = 3'd5;
	localparam logic [STATE_W-1:0] ST_CLOSED  = 3'd6;

	// phase ranks
	localparam logic [2:0] RANK_O   = 3'd0;
	localparam logic [2:0] RANK_S   = 3'd1;
	localparam logic [2:0] RANK_Q   = 3'd2;
	localparam logic [2:0] RANK_M   = 3'd3;
	localparam logic [2:0] RANK_E   = 3'd4;
	localparam logic [2:0] RANK_C   = 3'd5;
	localparam logic [2:0] NO_PHASE = 3'd7;

	// ASCII event codes
	localparam logic [7:0] EV_OPEN      = 8'h4F; // O
	localparam logic [7:0] EV_SYS_START = 8'h53; // S
	localparam logic [7:0] EV_MKT_START = 8'h51; // Q
	localparam logic [7:0] EV_MKT_END   = 8'h4D; // M
	localparam logic [7:0] EV_SYS_END   = 8'h45; // E
	localparam logic [7:0] EV_CLOSE     = 8'h43; // C

	// ASCII trading state codes
	localparam logic [7:0] TC_HALT  = 8'h48; // H
	localparam logic [7:0] TC_PAUSE = 8'h50; // P
	localparam logic [7:0] TC_QUOTE = 8'h51; // Q
	localparam logic [7:0] TC_TRADE = 8'h54; // T

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] locate;
		logic [7:0]  code_char;
		logic [31:0] seq_num;
		logic [47:0] ts_nanos;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  prior_state;
		logic [2:0]  new_state;
		logic        changed;
		logic        tradable;
		logic        log_valid;
		logic [31:0] log_index;
		logic [47:0] log_time;
		logic [7:0]  log_code;
	} result_t;

	typedef struct packed {
		logic               we;
		logic [STATE_W-1:0] data;
	} wr_t;

	typedef struct packed {
		logic       upd;
		logic [2:0] rank;
	} phase_upd_t;

	// {known, rank}
	function automatic logic [3:0] event_rank(input logic [7:0] c);
		logic [3:0] r;
		case (c)
			EV_OPEN:      r = {1'b1, RANK_O};
			EV_SYS_START: r = {1'b1, RANK_S};
			EV_MKT_START: r = {1'b1, RANK_Q};
			EV_MKT_END:   r = {1'b1, RANK_M};
			EV_SYS_END:   r = {1'b1, RANK_E};
			EV_CLOSE:     r = {1'b1, RANK_C};
			default:      r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [STATE_W-1:0] trade_state(input logic [7:0] c);
		logic [STATE_W-1:0] s;
		case (c)
			TC_HALT:  s = ST_HALTED;
			TC_PAUSE: s = ST_PAUSED;
			TC_QUOTE: s = ST_QUOTE;
			TC_TRADE: s = ST_TRADING;
			default:  s = ST_NONE;
		endcase
		return s;
	endfunction

endpackage

// ===== design/sts_ram.sv =====
// ----------------------------------------------------------------------------
// sts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/sts_exec.sv =====
// ----------------------------------------------------------------------------
// sts_exec
// Per-item decision logic: turns the fetched entry and phase into a result,
// a write-back and a phase update.
// ----------------------------------------------------------------------------
module sts_exec
	import sts_pkg::*;
(
	input  item_t              cmd,
	input  logic [STATE_W-1:0] raw,
	input  logic [2:0]         phase,
	input  logic               s_seen,
	output result_t            res,
	output wr_t                wr,
	output phase_upd_t         pu
);

	logic               late;
	logic               early;
	logic               addressable;
	logic [STATE_W-1:0] eff;
	logic [STATE_W-1:0] init;
	logic [STATE_W-1:0] req;
	logic [3:0]         ev;

	assign late        = (phase != NO_PHASE) && (phase >= RANK_M);
	assign early       = (phase == NO_PHASE) || (phase == RANK_O);
	assign addressable = (cmd.locate != '0) && ({1'b0, cmd.locate} < LOC_LIMIT);
	assign ev          = event_rank(cmd.code_char);
	assign req         = trade_state(cmd.code_char);
	assign init        = late ? ST_CLOSED : (early ? ST_PREOPEN : ST_HALTED);

	// Sweeps are folded into the read: once past market end every
	// registered entry reads closed, and preopen reads halted after S.
	always_comb begin
		if (!addressable || raw == ST_NONE) begin
			eff = ST_NONE;
		end else if (late) begin
			eff = ST_CLOSED;
		end else if (raw == ST_PREOPEN && s_seen) begin
			eff = ST_HALTED;
		end else begin
			eff = raw;
		end
	end

	always_comb begin
		res = '0;
		wr  = '0;
		pu  = '0;
		case (cmd.opcode)
			OP_REGISTER: begin
				if (cmd.locate == '0) begin
					res.status = STAT_LOC_ZERO;
				end else if (!addressable) begin
					res.status = STAT_UNREG;
				end else begin
					res.prior_state = eff;
					if (eff == ST_NONE) begin
						wr.we         = 1'b1;
						wr.data       = init;
						res.new_state = init;
					end else begin
						res.new_state = eff;
					end
				end
			end
			OP_SYSTEM: begin
				if (cmd.locate != '0) begin
					res.status = STAT_NONGLOBAL;
				end else if (!ev[3]) begin
					res.status = STAT_BAD_EVENT;
				end else if (phase != NO_PHASE && ev[2:0] <= phase) begin
					res.status = STAT_ORDER;
				end else begin
					pu.upd        = 1'b1;
					pu.rank       = ev[2:0];
					res.log_valid = 1'b1;
					res.log_index = cmd.seq_num;
					res.log_time  = cmd.ts_nanos;
					res.log_code  = cmd.code_char;
				end
			end
			OP_TRADE: begin
				res.prior_state = eff;
				res.new_state   = eff;
				if (eff == ST_NONE) begin
					res.status = STAT_UNREG;
				end else if (late) begin
					res.status = STAT_CLOSED;
				end else if (req == ST_NONE) begin
					res.status = STAT_BAD_STATE;
				end else begin
					wr.we         = 1'b1;
					wr.data       = req;
					res.new_state = req;
					res.changed   = (req != eff);
				end
			end
			OP_QUERY: begin
				res.prior_state = eff;
				res.new_state   = eff;
				if (eff == ST_NONE) begin
					res.status = STAT_UNREG;
				end
			end
			default: begin
				res = '0;
			end
		endcase
		res.tradable = (cmd.opcode != OP_SYSTEM) && (res.new_state == ST_TRADING);
	end

endmodule

// ===== design/session_trading_state_table.sv =====
// ----------------------------------------------------------------------------
// session_trading_state_table
// Daily market phase plus a per-locate trading state table held in one RAM.
// ----------------------------------------------------------------------------
//
//  channel  | signals                 | handshake
//  ---------+-------------------------+----------------------------------
//  command  | start, busy, cmd        | taken on clk when start && !busy
//  result   | done, result            | one-cycle strobe, cannot stall
//
//  Each item passes through S_EXEC: the accept edge issues the table read,
//  the edge that leaves S_EXEC writes the entry back and registers the
//  result, so done rises in the same cycle in which busy is low again.
//  This follows from the single read-modify-write of the table RAM; busy
//  stays high through it, so two accesses to one entry never overlap.
//  System events touch no RAM entries: phase sweeps are applied on read.
//  After reset a clearing pass writes every entry to unregistered, one
//  a cycle, with busy held high.
//  Results are never held off; each one is valid only in its done cycle.
//
module session_trading_state_table
	import sts_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   cmd,
	output logic    done,
	output result_t result
);

`include "assert_macros.svh"

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} fsm_t;

	fsm_t               state_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [2:0]         phase_q;
	logic               s_seen_q;
	logic               done_q;
	item_t              cmd_s1;
	result_t            result_q;

	logic               accept;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [STATE_W-1:0] ram_wdata;
	logic [STATE_W-1:0] ram_rdata;
	result_t            res;
	wr_t                wr;
	phase_upd_t         pu;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	// clearing pass owns the write port until it ends
	assign ram_we    = (state_q == S_CLEAR) || ((state_q == S_EXEC) && wr.we);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : cmd_s1.locate[ADDR_W-1:0];
	assign ram_wdata = (state_q == S_CLEAR) ? ST_NONE : wr.data;

	sts_ram #(
		.WIDTH(STATE_W),
		.DEPTH(LOCATE_COUNT)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(cmd.locate[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	sts_exec u_exec (
		.cmd   (cmd_s1),
		.raw   (ram_rdata),
		.phase (phase_q),
		.s_seen(s_seen_q),
		.res   (res),
		.wr    (wr),
		.pu    (pu)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			phase_q  <= NO_PHASE;
			s_seen_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(LOCATE_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (pu.upd) begin
						phase_q <= pu.rank;
						if (pu.rank == RANK_S) begin
							s_seen_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: item capture and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
		if (state_q == S_EXEC) begin
			result_q <= res;
		end
	end

	`STS_ASSERT(a_done_after_exec, done_q |-> $past(state_q == S_EXEC), "done without an executed item")
	`STS_ASSERT(a_no_idle_write, (state_q == S_IDLE) |-> !ram_we, "table written while idle")
	`STS_ASSERT(a_phase_advances, (phase_q != $past(phase_q)) |-> ($past(phase_q) == NO_PHASE || phase_q > $past(phase_q)), "phase moved backward")
	`STS_ASSERT(a_s_seen_on_s, $rose(s_seen_q) |-> (phase_q == RANK_S), "S flag set off an S event")
	`STS_ASSERT(a_clear_exit, ((state_q == S_IDLE) && $past(state_q == S_CLEAR)) |-> ($past(clr_q) == ADDR_W'(LOCATE_COUNT - 1)), "clearing pass ended early")

endmodule
